>>> rtl/core/gbkv_pkg.sv
// shared constants, codes and types of the gbk name byte validator
package gbkv_pkg;

    localparam int NAME_BYTES = 32;
    localparam int MAX_CHARS  = 16;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 8;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_EMPTY    = 2'd1,
        VERDICT_TOO_LONG = 2'd2,
        VERDICT_INVALID  = 2'd3
    } verdict_t;

    typedef struct packed {
        logic is_zero;
        logic is_high;
        logic ascii_ok;
        logic lead_ok;
        logic trail_ok;
    } byte_class_t;

    typedef struct packed {
        verdict_t verdict;
        logic     error_seen;
        logic     lead_pending;
    } scan_status_t;

endpackage

>>> rtl/core/gbkv_classify.sv
// byte classifier: ascii name characters and gbk lead and trail ranges
module gbkv_classify (
    input  logic [gbkv_pkg::BYTE_W-1:0] cur_byte,
    input  logic [gbkv_pkg::BYTE_W-1:0] lead_byte,
    output gbkv_pkg::byte_class_t       byte_class
);
    import gbkv_pkg::*;

    always_comb begin
        byte_class.is_zero  = (cur_byte == 8'h00);
        byte_class.is_high  = cur_byte[BYTE_W-1];
        byte_class.ascii_ok = (cur_byte inside {[8'h30:8'h39], [8'h41:8'h5A],
                                                [8'h61:8'h7A], 8'h20});
        byte_class.lead_ok  = (lead_byte inside {[8'h81:8'hFE]}) &&
                              !(lead_byte inside {[8'hA1:8'hA9]});
        byte_class.trail_ok = (cur_byte inside {[8'h40:8'hFE]}) && (cur_byte != 8'h7F);
    end

endmodule

>>> rtl/core/gbkv_scan.sv
// name scan state: byte and character counts, open lead byte, first error
module gbkv_scan (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic [gbkv_pkg::BYTE_W-1:0] cur_byte,
    output gbkv_pkg::scan_status_t      status
);
    import gbkv_pkg::*;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0] char_count_reg, char_count_next;
    logic [BYTE_W-1:0]  lead_byte_reg, lead_byte_next;
    logic               lead_pending_reg, lead_pending_next;
    logic               error_seen_reg, error_seen_next;
    verdict_t           error_code_reg, error_code_next;

    byte_class_t        byte_class;
    logic [COUNT_W:0]   total;
    logic [COUNT_W-1:0] nbytes;

    gbkv_classify u_classify (
        .cur_byte   (cur_byte),
        .lead_byte  (lead_byte_reg),
        .byte_class (byte_class)
    );

    always_comb begin
        nbytes = lead_pending_reg ? COUNT_W'(2) : COUNT_W'(1);
        total  = {1'b0, byte_count_reg} + {1'b0, nbytes};

        if (error_seen_reg) begin
            status.verdict = error_code_reg;
        end else if (lead_pending_reg) begin
            status.verdict = VERDICT_INVALID;
        end else if (byte_count_reg == '0) begin
            status.verdict = VERDICT_EMPTY;
        end else begin
            status.verdict = VERDICT_OK;
        end
        status.error_seen   = error_seen_reg;
        status.lead_pending = lead_pending_reg;
    end

    always_comb begin
        byte_count_next   = byte_count_reg;
        char_count_next   = char_count_reg;
        lead_byte_next    = lead_byte_reg;
        lead_pending_next = lead_pending_reg;
        error_seen_next   = error_seen_reg;
        error_code_next   = error_code_reg;

        if (byte_class.is_zero) begin
            byte_count_next   = '0;
            char_count_next   = '0;
            lead_byte_next    = '0;
            lead_pending_next = 1'b0;
            error_seen_next   = 1'b0;
            error_code_next   = VERDICT_OK;
        end else if (error_seen_reg) begin
            // swallow until terminator
        end else if (lead_pending_reg || !byte_class.is_high) begin
            lead_pending_next = 1'b0;
            if (!lead_pending_reg && (char_count_reg >= COUNT_W'(MAX_CHARS))) begin
                error_seen_next = 1'b1;
                error_code_next = VERDICT_TOO_LONG;
            end else if (lead_pending_reg ? !(byte_class.lead_ok && byte_class.trail_ok)
                                          : !byte_class.ascii_ok) begin
                error_seen_next = 1'b1;
                error_code_next = VERDICT_INVALID;
            end else begin
                char_count_next = char_count_reg + COUNT_W'(1);
                byte_count_next = total[COUNT_W-1:0];
                if (total >= (COUNT_W+1)'(NAME_BYTES)) begin
                    error_seen_next = 1'b1;
                    error_code_next = VERDICT_TOO_LONG;
                end
            end
        end else if (char_count_reg >= COUNT_W'(MAX_CHARS)) begin
            error_seen_next = 1'b1;
            error_code_next = VERDICT_TOO_LONG;
        end else begin
            lead_byte_next    = cur_byte;
            lead_pending_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            char_count_reg   <= '0;
            lead_byte_reg    <= '0;
            lead_pending_reg <= 1'b0;
            error_seen_reg   <= 1'b0;
            error_code_reg   <= VERDICT_OK;
        end else if (step_en) begin
            byte_count_reg   <= byte_count_next;
            char_count_reg   <= char_count_next;
            lead_byte_reg    <= lead_byte_next;
            lead_pending_reg <= lead_pending_next;
            error_seen_reg   <= error_seen_next;
            error_code_reg   <= error_code_next;
        end
    end

endmodule

>>> rtl/core/gbk_name_byte_validator.sv
// top level of the gbk name byte validator: input register, scan, verdict register
//
// channel   dir  tdata fields (lsb up)        request carries
// s_axis    in   name_byte [7:0]              one byte of a name, zero ends it
// m_axis    out  verdict [1:0], zero pad      one verdict per terminator
//
// one byte per cycle while no terminator waits on m_; s_ to m_ goes via the
// input and verdict registers; the byte rate is set by the scan state update loop
// aresetn clears counts, error state and both valid flags
// a stalled verdict holds only terminators; other bytes keep flowing
module gbk_name_byte_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // name_byte [7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // verdict [1:0], zeros [7:2]
);
    import gbkv_pkg::*;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg;
    verdict_t           out_verdict_reg;

    logic               out_free;
    logic               in_is_zero;
    logic               advance;
    scan_status_t       status;

    assign out_free   = !out_valid_reg || m_tready;
    assign in_is_zero = (in_byte_reg == '0);
    assign advance    = in_valid_reg && (!in_is_zero || out_free);
    assign s_tready   = !in_valid_reg || advance;

    gbkv_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .cur_byte (in_byte_reg),
        .status   (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_is_zero) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_is_zero) begin
            out_verdict_reg <= status.verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_verdict_reg};

    a_verdict_loaded : assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_is_zero) |=> (m_tvalid && (m_tdata[1:0] == $past(status.verdict))))
        else $error("terminator did not load its verdict");

    a_no_spurious_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (!(advance && in_is_zero)) |=> (m_tvalid == ($past(m_tvalid) && !$past(m_tready))))
        else $error("verdict appeared without a terminator");

    a_error_closes_pair : assert property (@(posedge aclk) disable iff (!aresetn)
        !(status.error_seen && status.lead_pending))
        else $error("open lead byte kept after an error");

    a_held_byte_kept : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled byte lost");

endmodule
